// ===== sv/pls_pkg.sv =====
`timescale 1ns / 1ps
package pls_pkg;

  localparam int W         = 32;
  localparam int F         = 16;
  localparam int SQ_BITS   = 2 * W + 2;
  localparam int ROOT_BITS = W + 1;
  localparam int SQR_REM   = ROOT_BITS + 3;
  localparam int RAD_REM   = SQ_BITS + 1;
  localparam int DIR_Q     = F + 1;
  localparam int DIR_REM   = ROOT_BITS + 1;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [W-1:0] INV_FOUR_PI = 32'h145F306E;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_POS_Z   = 3'd2,
    REG_FLUX_R  = 3'd3,
    REG_FLUX_G  = 3'd4,
    REG_FLUX_B  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][W-1:0]    mag;
    logic [2:0]           neg;
    logic [2:0][W-1:0]    inten;
    logic [2:0]           sat;
    logic [SQ_BITS-1:0]   s;
    logic                 deg;
  } front_t;

  typedef struct packed {
    logic [SQ_BITS-1:0]       s;
    logic [SQR_REM-1:0]       rem;
    logic [ROOT_BITS-1:0]     root;
    logic [2:0][RAD_REM-1:0]  rad_rem;
    logic [2:0][W-1:0]        rad_q;
    logic [2:0]               sat;
    logic [2:0][W-1:0]        mag;
    logic [2:0]               neg;
    logic                     deg;
  } root_t;

  typedef struct packed {
    logic [2:0][DIR_REM-1:0]  rem;
    logic [2:0][DIR_Q-1:0]    q;
    logic [ROOT_BITS-1:0]     root;
    logic [2:0][W-1:0]        mag;
    logic [2:0]               neg;
    logic [2:0][W-1:0]        rad;
    logic                     deg;
  } norm_t;

  typedef struct packed {
    logic              deg;
    logic [2:0][W-1:0] rad;
    logic [W-1:0]      light_dist;
    logic [2:0][W-1:0] dir;
  } result_t;

endpackage

// ===== sv/pls_front.sv =====
`timescale 1ns / 1ps
module pls_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][pls_pkg::W-1:0]    hit,
  input  logic [2:0][pls_pkg::W-1:0]    pos,
  input  logic [2:0][pls_pkg::W-1:0]    flux,
  output logic                          out_valid,
  output pls_pkg::front_t               out_data
);

  logic v1, v2, v3;
  logic [2:0][pls_pkg::W-1:0]   mag1, mag1_next, mag2, inten2, inten2_next;
  logic [2:0]                   neg1, neg1_next, neg2;
  logic [2:0][2*pls_pkg::W-1:0] prod1, prod1_next, sq2, sq2_next;
  pls_pkg::front_t              f3_next;

  // stage 1: difference magnitudes and flux scaling
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if ($signed(pos[c]) >= $signed(hit[c])) begin
        mag1_next[c] = pos[c] - hit[c];
        neg1_next[c] = 1'b0;
      end else begin
        mag1_next[c] = hit[c] - pos[c];
        neg1_next[c] = 1'b1;
      end
      prod1_next[c] = flux[c] * pls_pkg::INV_FOUR_PI;
    end
  end

  // stage 2: squares and rounded intensity
  always_comb begin
    logic [2*pls_pkg::W-1:0] rnd;
    rnd = '0;
    for (int c = 0; c < 3; c++) begin
      sq2_next[c]    = mag1[c] * mag1[c];
      rnd            = prod1[c] + (64'd1 << 31);
      inten2_next[c] = rnd[2*pls_pkg::W-1:pls_pkg::W];
    end
  end

  // stage 3: squared distance, saturation check for radiance
  always_comb begin
    logic [pls_pkg::SQ_BITS-1:0] s;
    s = {2'b00, sq2[0]} + {2'b00, sq2[1]} + {2'b00, sq2[2]};
    f3_next.s     = s;
    f3_next.deg   = (s == '0);
    f3_next.mag   = mag2;
    f3_next.neg   = neg2;
    f3_next.inten = inten2;
    for (int c = 0; c < 3; c++) begin
      f3_next.sat[c] = {{(pls_pkg::SQ_BITS-pls_pkg::W){1'b0}}, inten2[c]} >= s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1     <= mag1_next;
      neg1     <= neg1_next;
      prod1    <= prod1_next;
      mag2     <= mag1;
      neg2     <= neg1;
      sq2      <= sq2_next;
      inten2   <= inten2_next;
      out_data <= f3_next;
    end
  end

  assign out_valid = v3;

endmodule

// ===== sv/pls_root.sv =====
`timescale 1ns / 1ps
module pls_root (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  pls_pkg::front_t  in_data,
  output logic             out_valid,
  output pls_pkg::root_t   out_data
);

  localparam int N = pls_pkg::ROOT_BITS;

  pls_pkg::root_t st [N];
  pls_pkg::root_t nx [N];
  logic [N-1:0]   v;
  pls_pkg::root_t init;

  always_comb begin
    init.s    = in_data.s;
    init.rem  = '0;
    init.root = '0;
    init.rad_q = '0;
    init.sat  = in_data.sat;
    init.mag  = in_data.mag;
    init.neg  = in_data.neg;
    init.deg  = in_data.deg;
    for (int c = 0; c < 3; c++) begin
      init.rad_rem[c] = {{(pls_pkg::RAD_REM-pls_pkg::W){1'b0}}, in_data.inten[c]};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    pls_pkg::root_t src;
    assign src = (k == 0) ? init : st[(k == 0) ? 0 : k - 1];

    // one root bit, and (in every stage but the last) one quotient bit of each radiance division
    always_comb begin
      logic [pls_pkg::SQR_REM-1:0] rsh, trial;
      logic [pls_pkg::RAD_REM-1:0] dsh, den;
      logic                        take;
      nx[k] = src;
      rsh   = {src.rem[pls_pkg::SQR_REM-3:0], src.s[2*B+1], src.s[2*B]};
      trial = {1'b0, src.root, 2'b01};
      take  = (rsh >= trial);
      nx[k].rem  = take ? rsh - trial : rsh;
      nx[k].root = {src.root[N-2:0], take};
      den = {1'b0, src.s};
      for (int c = 0; c < 3; c++) begin
        dsh = {src.rad_rem[c][pls_pkg::RAD_REM-2:0], 1'b0};
        if (k < pls_pkg::W) begin
          nx[k].rad_rem[c] = (dsh >= den) ? dsh - den : dsh;
          nx[k].rad_q[c]   = {src.rad_q[c][pls_pkg::W-2:0], dsh >= den};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en) v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
    end

    always_ff @(posedge clk) begin
      if (en) st[k] <= nx[k];
    end
  end

  assign out_valid = v[N-1];
  assign out_data  = st[N-1];

endmodule

// ===== sv/pls_norm.sv =====
`timescale 1ns / 1ps
module pls_norm (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  pls_pkg::root_t    in_data,
  output logic              out_valid,
  output pls_pkg::result_t  out_data
);

  localparam int N = pls_pkg::DIR_Q;

  pls_pkg::norm_t st [N];
  pls_pkg::norm_t nx [N];
  logic [N-1:0]   v;
  pls_pkg::norm_t init;

  always_comb begin
    init.q    = '0;
    init.root = in_data.root;
    init.mag  = in_data.mag;
    init.neg  = in_data.neg;
    init.deg  = in_data.deg;
    for (int c = 0; c < 3; c++) begin
      init.rem[c] = {{(pls_pkg::DIR_REM-pls_pkg::W+1){1'b0}}, in_data.mag[c][pls_pkg::W-1:1]};
      init.rad[c] = in_data.sat[c] ? '1 : in_data.rad_q[c];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    pls_pkg::norm_t src;
    assign src = (k == 0) ? init : st[(k == 0) ? 0 : k - 1];

    // one quotient bit of each direction component
    always_comb begin
      logic [pls_pkg::DIR_REM-1:0] rsh, den;
      logic                        nb;
      nx[k] = src;
      den = {1'b0, src.root};
      for (int c = 0; c < 3; c++) begin
        nb  = (B == pls_pkg::F) ? src.mag[c][0] : 1'b0;
        rsh = {src.rem[c][pls_pkg::DIR_REM-2:0], nb};
        nx[k].rem[c] = (rsh >= den) ? rsh - den : rsh;
        nx[k].q[c]   = {src.q[c][N-2:0], rsh >= den};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en) v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
    end

    always_ff @(posedge clk) begin
      if (en) st[k] <= nx[k];
    end
  end

  // apply signs, saturate distance, zero everything for coincident points
  always_comb begin
    pls_pkg::norm_t   l;
    logic [pls_pkg::W-1:0] qe;
    l = st[N-1];
    qe = '0;
    out_data.deg  = l.deg;
    out_data.rad  = l.rad;
    out_data.light_dist = l.root[pls_pkg::ROOT_BITS-1] ? '1 : l.root[pls_pkg::W-1:0];
    for (int c = 0; c < 3; c++) begin
      qe = {{(pls_pkg::W-N){1'b0}}, l.q[c]};
      out_data.dir[c] = l.neg[c] ? (~qe + 1'b1) : qe;
    end
    if (l.deg) begin
      out_data.rad  = '0;
      out_data.light_dist = '0;
      out_data.dir  = '0;
    end
  end

  assign out_valid = v[N-1];

endmodule

// ===== sv/point_light_sample_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake             Payload
// s_        in   s_tvalid / s_tready   s_tdata: hit_x, hit_y, hit_z
// m_        out  m_tvalid / m_tready   m_tdata: dir_x..z, light_distance, radiance r/g/b;
//                                      m_tuser: degenerate
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// Stages: 3 front stages, 33 root stages, 17 direction-divide stages, output register.
// One item per cycle sustained while the output is not stalled.
// The square-root stage chain sets the depth: one root bit per stage, with the
// radiance divisions by the squared distance sharing the same stages.
// Reset (rst, synchronous) clears valid bits and the light registers to zero.
// A stall at the output fills a one-item skid register and then freezes the pipe.
module point_light_sample_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [3*pls_pkg::W-1:0]           s_tdata,   // hit_x, hit_y, hit_z
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // dir_x, dir_y, dir_z, light_distance, radiance_red, radiance_green, radiance_blue
  output logic [7*pls_pkg::W-1:0]           m_tdata,
  output logic [0:0]                        m_tuser,   // degenerate
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pls_pkg::W-1:0]             cfg_data
);

  logic [2:0][pls_pkg::W-1:0] pos, flux, hit;
  logic                       en;
  logic                       f_valid, r_valid, n_valid;
  pls_pkg::front_t            f_data;
  pls_pkg::root_t             r_data;
  pls_pkg::result_t           n_data, out_res, skid;
  logic                       out_v, skid_v;

  assign cfg_ready = 1'b1;
  assign hit       = s_tdata;

  // light registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      flux <= '0;
    end else if (cfg_valid) begin
      case (pls_pkg::reg_idx_t'(cfg_index))
        pls_pkg::REG_POS_X:  pos[0]  <= cfg_data;
        pls_pkg::REG_POS_Y:  pos[1]  <= cfg_data;
        pls_pkg::REG_POS_Z:  pos[2]  <= cfg_data;
        pls_pkg::REG_FLUX_R: flux[0] <= cfg_data;
        pls_pkg::REG_FLUX_G: flux[1] <= cfg_data;
        pls_pkg::REG_FLUX_B: flux[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the skid register is holding an item
  assign en       = !skid_v;
  assign s_tready = en;

  pls_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .hit(hit),
    .pos(pos), .flux(flux), .out_valid(f_valid), .out_data(f_data)
  );

  pls_root u_root (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .in_data(f_data),
    .out_valid(r_valid), .out_data(r_data)
  );

  pls_norm u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_valid), .in_data(r_data),
    .out_valid(n_valid), .out_data(n_data)
  );

  // output register plus skid: take the skid item first, else the pipe tail
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      out_v  <= skid_v || n_valid;
      skid_v <= 1'b0;
    end else if (n_valid && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      out_res <= skid_v ? skid : n_data;
    end else if (n_valid && en) begin
      skid <= n_data;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {out_res.rad, out_res.light_dist, out_res.dir};
  assign m_tuser  = out_res.deg;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v) else $error("skid holds an item while output is empty");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0)) else $error("degenerate result not zeroed");
  a_dist_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (out_res.light_dist != '0))
    else $error("zero distance not flagged");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_v |=> !(skid_v && !$past(m_tready)) || $stable(skid)) else $error("skid item changed");
`endif

endmodule
